// ===== hw/rtl/heater_interlock_ac_load_monitor_assert.svh =====
// assertion macros shared by the checker
`ifndef HEATER_INTERLOCK_AC_LOAD_MONITOR_ASSERT_SVH
`define HEATER_INTERLOCK_AC_LOAD_MONITOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HILM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HILM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hilm_pkg.sv =====
`default_nettype none

package hilm_pkg;

  // item kinds
  localparam logic [1:0] KIND_SET_HEATER = 2'd0;
  localparam logic [1:0] KIND_ALL_OFF    = 2'd1;
  localparam logic [1:0] KIND_REQUEST    = 2'd2;
  localparam logic [1:0] KIND_SAMPLE     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_BASELINE   = 3'd0;
  localparam logic [2:0] CFG_SCALE_MULT = 3'd1;
  localparam logic [2:0] CFG_SCALE_SHFT = 3'd2;
  localparam logic [2:0] CFG_SPAN_THR   = 3'd3;
  localparam logic [2:0] CFG_MAINS_V    = 3'd4;

  // configuration reset values
  localparam logic [9:0] BASELINE_RST   = 10'd512;
  localparam logic [7:0] SCALE_MULT_RST = 8'd1;
  localparam logic [3:0] SCALE_SHFT_RST = 4'd0;
  localparam logic [9:0] SPAN_THR_RST   = 10'd16;
  localparam logic [8:0] MAINS_V_RST    = 9'd230;

  localparam logic [7:0]  CURRENT_SAT  = 8'd255;
  localparam logic [16:0] POWER_ROUND  = 17'd5;
  // ceil(2^20 / 10), exact quotient for dividends below 2^18
  localparam logic [16:0] DIV10_RECIP  = 17'd104858;
  localparam int          DIV10_SHIFT  = 20;

  typedef struct packed {
    logic apply;     // take the accepted item
    logic fin_stat;  // avg, span, load, valid flag
    logic fin_mul;   // level times numerator
    logic fin_cur;   // shift, saturate, times volts
    logic fin_div;   // rounded divide by ten via reciprocal
    logic fin_pow;   // store power
    logic emit;      // load output register
  } hilm_cmd_t;

  typedef struct packed {
    logic win_last;  // the offered item closes the window
  } hilm_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hilm_datapath.sv =====
`default_nettype none

module hilm_datapath import hilm_pkg::*; #(
  parameter int WINDOW_LOG2 = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hilm_cmd_t   cmd,
  output hilm_stat_t       stat,
  input  wire logic [1:0]  in_kind,
  input  wire logic        in_heater_select,
  input  wire logic        in_enable,
  input  wire logic [9:0]  in_sample,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  output logic             out_accepted,
  output logic             out_mash_on,
  output logic             out_boil_on,
  output logic             out_busy_res,
  output logic             out_result_valid,
  output logic             out_load_present,
  output logic [9:0]       out_window_min,
  output logic [9:0]       out_window_max,
  output logic [9:0]       out_window_avg,
  output logic [9:0]       out_window_span,
  output logic [7:0]       out_current_tenths,
  output logic [13:0]      out_power_watts
);

  localparam int SumW = 10 + WINDOW_LOG2;
  localparam int CntW = WINDOW_LOG2 + 1;
  localparam logic [CntW-1:0] CntLast = CntW'((1 << WINDOW_LOG2) - 1);

  // configuration
  logic [9:0] base_r;
  logic [7:0] mult_r;
  logic [3:0] shft_r;
  logic [9:0] thr_r;
  logic [8:0] volts_r;

  // architectural state
  logic            mash_r, mash_nxt;
  logic            boil_r, boil_nxt;
  logic            discard_r, discard_nxt;
  logic            active_r, active_nxt;
  logic            valid_r, valid_nxt;
  logic [9:0]      min_r, min_nxt;
  logic [9:0]      max_r, max_nxt;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [9:0]      avg_r, avg_nxt;
  logic [9:0]      span_r, span_nxt;
  logic            load_r, load_nxt;
  logic [7:0]      cur_r, cur_nxt;
  logic [13:0]     pow_r, pow_nxt;
  logic            acc_r, acc_nxt;

  // finish pipeline products
  logic [17:0] prod1_r;
  logic [16:0] prod2_r;
  logic [33:0] prod3_r;

  logic        h_self, h_other, h_change;
  logic [9:0]  level;
  logic [15:0] cur_shifted;
  logic [7:0]  cur_sat;
  logic [16:0] pow_dividend;

  assign stat.win_last = (in_kind == KIND_SAMPLE) && active_r && (cnt_r == CntLast);

  assign h_self   = in_heater_select ? boil_r : mash_r;
  assign h_other  = in_heater_select ? mash_r : boil_r;
  assign h_change = (h_self != in_enable) || (in_enable && h_other);

  assign level        = (avg_r > base_r) ? (avg_r - base_r) : 10'd0;
  assign cur_shifted  = prod1_r[15:0] >> shft_r;
  assign cur_sat      = (|cur_shifted[15:8]) ? CURRENT_SAT : cur_shifted[7:0];
  assign pow_dividend = prod2_r + POWER_ROUND;

  always_comb begin
    mash_nxt    = mash_r;
    boil_nxt    = boil_r;
    discard_nxt = discard_r;
    active_nxt  = active_r;
    valid_nxt   = valid_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    avg_nxt     = avg_r;
    span_nxt    = span_r;
    load_nxt    = load_r;
    cur_nxt     = cur_r;
    pow_nxt     = pow_r;
    acc_nxt     = acc_r;
    if (cmd.apply) begin
      acc_nxt = 1'b1;
      unique case (in_kind)
        KIND_SET_HEATER: begin
          if (in_heater_select) begin
            boil_nxt = in_enable;
            mash_nxt = in_enable ? 1'b0 : mash_r;
          end else begin
            mash_nxt = in_enable;
            boil_nxt = in_enable ? 1'b0 : boil_r;
          end
          if (h_change) begin
            discard_nxt = 1'b1;
            valid_nxt   = 1'b0;
          end
        end
        KIND_ALL_OFF: begin
          if (mash_r || boil_r) begin
            discard_nxt = 1'b1;
            valid_nxt   = 1'b0;
          end
          mash_nxt = 1'b0;
          boil_nxt = 1'b0;
        end
        KIND_REQUEST: begin
          if (active_r) begin
            acc_nxt = 1'b0;
          end else begin
            min_nxt    = '0;
            max_nxt    = '0;
            sum_nxt    = '0;
            cnt_nxt    = '0;
            avg_nxt    = '0;
            span_nxt   = '0;
            load_nxt   = 1'b0;
            cur_nxt    = '0;
            pow_nxt    = '0;
            valid_nxt  = 1'b0;
            active_nxt = 1'b1;
          end
        end
        KIND_SAMPLE: begin
          if (active_r) begin
            if (cnt_r == '0) begin
              min_nxt = in_sample;
              max_nxt = in_sample;
            end else begin
              if (in_sample < min_r) min_nxt = in_sample;
              if (in_sample > max_r) max_nxt = in_sample;
            end
            sum_nxt = sum_r + SumW'(in_sample);
            cnt_nxt = cnt_r + CntW'(1);
            if (cnt_r == CntLast) active_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (cmd.fin_stat) begin
      avg_nxt  = sum_r[SumW-1 -: 10];
      span_nxt = max_r - min_r;
      load_nxt = (max_r - min_r) >= thr_r;
      if (discard_r) begin
        discard_nxt = 1'b0;
        valid_nxt   = 1'b0;
      end else begin
        valid_nxt = 1'b1;
      end
    end
    if (cmd.fin_cur) cur_nxt = cur_sat;
    if (cmd.fin_pow) pow_nxt = prod3_r[DIV10_SHIFT +: 14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= BASELINE_RST;
      mult_r    <= SCALE_MULT_RST;
      shft_r    <= SCALE_SHFT_RST;
      thr_r     <= SPAN_THR_RST;
      volts_r   <= MAINS_V_RST;
      mash_r    <= 1'b0;
      boil_r    <= 1'b0;
      discard_r <= 1'b0;
      active_r  <= 1'b0;
      valid_r   <= 1'b0;
      min_r     <= '0;
      max_r     <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
      avg_r     <= '0;
      span_r    <= '0;
      load_r    <= 1'b0;
      cur_r     <= '0;
      pow_r     <= '0;
      acc_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASELINE:   base_r  <= cfg_data;
          CFG_SCALE_MULT: mult_r  <= cfg_data[7:0];
          CFG_SCALE_SHFT: shft_r  <= cfg_data[3:0];
          CFG_SPAN_THR:   thr_r   <= cfg_data;
          CFG_MAINS_V:    volts_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      mash_r    <= mash_nxt;
      boil_r    <= boil_nxt;
      discard_r <= discard_nxt;
      active_r  <= active_nxt;
      valid_r   <= valid_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      avg_r     <= avg_nxt;
      span_r    <= span_nxt;
      load_r    <= load_nxt;
      cur_r     <= cur_nxt;
      pow_r     <= pow_nxt;
      acc_r     <= acc_nxt;
    end
  end

  // multiplier chain, each product loaded in its own finish step
  always_ff @(posedge clk) begin
    if (cmd.fin_mul) prod1_r <= {8'd0, level} * {10'd0, mult_r};
    if (cmd.fin_cur) prod2_r <= {9'd0, cur_sat} * {8'd0, volts_r};
    if (cmd.fin_div) prod3_r <= {17'd0, pow_dividend} * {17'd0, DIV10_RECIP};
  end

  // output register, holds the snapshot while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_accepted       <= acc_r;
      out_mash_on        <= mash_r;
      out_boil_on        <= boil_r;
      out_busy_res       <= active_r;
      out_result_valid   <= valid_r;
      out_load_present   <= load_r;
      out_window_min     <= min_r;
      out_window_max     <= max_r;
      out_window_avg     <= avg_r;
      out_window_span    <= span_r;
      out_current_tenths <= cur_r;
      out_power_watts    <= pow_r;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hilm_ctrl.sv =====
`default_nettype none

module hilm_ctrl import hilm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire hilm_stat_t stat,
  output hilm_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIN1 = 3'd1;
  localparam logic [2:0] ST_FIN2 = 3'd2;
  localparam logic [2:0] ST_FIN3 = 3'd3;
  localparam logic [2:0] ST_FIN4 = 3'd4;
  localparam logic [2:0] ST_FIN5 = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.apply = 1'b1;
          state_nxt = stat.win_last ? ST_FIN1 : ST_EMIT;
        end
      end
      ST_FIN1: begin
        cmd.fin_stat = 1'b1;
        state_nxt    = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = ST_FIN3;
      end
      ST_FIN3: begin
        cmd.fin_cur = 1'b1;
        state_nxt   = ST_FIN4;
      end
      ST_FIN4: begin
        cmd.fin_div = 1'b1;
        state_nxt   = ST_FIN5;
      end
      ST_FIN5: begin
        cmd.fin_pow = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        // wait until the previous item has left the output register
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/heater_interlock_ac_load_monitor.sv =====
// Heater interlock and AC load monitor.
// Input channel (in_valid/in_ready) carries one item: a heater set, an all-off,
// a measurement request or one ADC sample. Output channel (out_valid/out_ready)
// returns one status snapshot per item, taken after the item is applied.
// Configuration is written through cfg_we/cfg_index/cfg_data. The user must
// write it only while no item is in flight; the block does not enforce this.
// One item is worked on at a time. Most items go from accept straight to the
// emit step; the next item is taken once the output register is loaded.
// The sample that closes a window first runs five finish steps: the window
// statistics, the level multiply, the saturating shift with the volts multiply
// and the divide by ten done as a reciprocal multiply, then the power store.
// The output register holds its item while out_ready is low; the next item
// is still taken and worked on, and waits in its emit step until the
// register is free, so nothing is lost under any stall pattern.
// Synchronous reset (rst_n low) restores the configuration defaults,
// switches both heaters off, closes any window and clears all results.
`default_nettype none

module heater_interlock_ac_load_monitor import hilm_pkg::*; #(
  parameter int WINDOW_LOG2 = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic        in_heater_select,
  input  wire logic        in_enable,
  input  wire logic [9:0]  in_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic             out_mash_on,
  output logic             out_boil_on,
  output logic             out_busy_res,
  output logic             out_result_valid,
  output logic             out_load_present,
  output logic [9:0]       out_window_min,
  output logic [9:0]       out_window_max,
  output logic [9:0]       out_window_avg,
  output logic [9:0]       out_window_span,
  output logic [7:0]       out_current_tenths,
  output logic [13:0]      out_power_watts,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  hilm_cmd_t  cmd;
  hilm_stat_t stat;

  hilm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hilm_datapath #(
    .WINDOW_LOG2 (WINDOW_LOG2)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_heater_select   (in_heater_select),
    .in_enable          (in_enable),
    .in_sample          (in_sample),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_accepted       (out_accepted),
    .out_mash_on        (out_mash_on),
    .out_boil_on        (out_boil_on),
    .out_busy_res       (out_busy_res),
    .out_result_valid   (out_result_valid),
    .out_load_present   (out_load_present),
    .out_window_min     (out_window_min),
    .out_window_max     (out_window_max),
    .out_window_avg     (out_window_avg),
    .out_window_span    (out_window_span),
    .out_current_tenths (out_current_tenths),
    .out_power_watts    (out_power_watts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hilm_checker.sv =====
`default_nettype none
`include "heater_interlock_ac_load_monitor_assert.svh"

module hilm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_accepted,
  input wire logic        out_mash_on,
  input wire logic        out_boil_on,
  input wire logic        out_busy_res,
  input wire logic        out_result_valid,
  input wire logic [13:0] out_power_watts
);

  // heaters are interlocked
  `HILM_ASSERT_NOW(a_heater_excl, out_valid, !(out_mash_on && out_boil_on), "both heaters on")

  // a refused request only happens with a window running
  `HILM_ASSERT_NOW(a_refuse_busy, out_valid && !out_accepted, out_busy_res, "refused while idle")

  // a valid result means the window has closed
  `HILM_ASSERT_NOW(a_valid_idle, out_valid && out_result_valid, !out_busy_res, "valid while busy")

  // one item in flight at a time
  `HILM_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")

  `HILM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_power_watts) && $stable(out_mash_on), "stalled item changed")

endmodule

bind heater_interlock_ac_load_monitor hilm_checker u_hilm_checker (.*);

`default_nettype wire
